// ----- design/asfc_pkg.sv -----
// Shared types and constants of the audio stream frame checker.
// Holds command, result and error codes plus the FNV-1a step function.
// Depends on nothing; used by audio_stream_frame_checker_unit.
`default_nettype none

package asfc_pkg;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PAYLOAD = 2'd1,
        CMD_END     = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_STARTED = 2'd0,
        KIND_CHUNK   = 2'd1,
        KIND_ENDED   = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NESTED          = 4'd0,
        ERR_TOO_LARGE       = 4'd1,
        ERR_END_NO_START    = 4'd2,
        ERR_SEQ             = 4'd3,
        ERR_END_BYTES       = 4'd4,
        ERR_END_CHUNKS      = 4'd5,
        ERR_PAYLOAD_BYTES   = 4'd6,
        ERR_PAYLOAD_CHUNKS  = 4'd7,
        ERR_NO_STREAM       = 4'd8,
        ERR_BYTES_OVERRUN   = 4'd9,
        ERR_CHUNKS_OVERRUN  = 4'd10
    } t_err;

    localparam logic [31:0] FNV_SEED  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // One FNV-1a step. The prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0,
    // so the product modulo 2^32 is a sum of shifted copies.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

// ----- design/audio_stream_frame_checker_unit.sv -----
// Top level of the audio stream frame checker: command decode, stream state,
// FNV-1a checksum and the result register. Depends on asfc_pkg.
`default_nettype none

// Usage
// -----
// The input channel (i_in_valid / o_in_ready) carries one command per request:
// stream start, one payload byte, or stream end, with all fields as separate
// ports. The output channel (o_out_valid / i_out_ready) carries at most one
// result request per command: stream started, chunk done, stream ended or an
// error with its code.
// Each command is decoded and applied to the stream state in the cycle it is
// accepted, so one command is taken every clock cycle while no stalled result
// holds o_in_ready low. The FNV-1a multiply is a fixed sum of shifted copies
// of the checksum, which is the longest path from the state registers back
// to themselves. A result appears in the cycle after its command was accepted.
// The result register parts the two channels: a new command is taken while a
// held result is being delivered in the same cycle. When the receiver stalls
// with a result pending, o_in_ready drops until that result is taken; commands
// never get lost or reordered.
// Synchronous active-low reset closes any open stream, clears all counters and
// the checksum, and empties the result register. Any error also closes the
// stream and clears all of its state.
module audio_stream_frame_checker_unit #(
    parameter int CHUNK_MAX = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Command channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_seq,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_in_chunk,
    input  wire logic [23:0] i_total_bytes,
    input  wire logic [15:0] i_total_chunks,
    input  wire logic [15:0] i_declared_chunk_size,
    input  wire logic        i_has_total_bytes,
    input  wire logic        i_has_total_chunks,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [3:0]       o_error_code,
    output logic [31:0]      o_stream_seq,
    output logic [15:0]      o_chunk_index,
    output logic [10:0]      o_chunk_size,
    output logic [23:0]      o_bytes_received,
    output logic [31:0]      o_checksum,
    output logic             o_final_chunk,
    output logic [23:0]      o_out_total_bytes,
    output logic [15:0]      o_out_total_chunks
);

    // The per-chunk byte counter saturates at CHUNK_MAX + 1.
    localparam int CW = $clog2(CHUNK_MAX + 2);
    localparam logic [CW-1:0] CHUNK_LIMIT = CW'(CHUNK_MAX);

    // Stream state.
    logic          r_stream_active, n_stream_active;
    logic [31:0]   r_active_seq, n_active_seq;
    logic [23:0]   r_expected_bytes, n_expected_bytes;
    logic [15:0]   r_expected_chunks, n_expected_chunks;
    logic [23:0]   r_received_bytes, n_received_bytes;
    logic [15:0]   r_received_chunks, n_received_chunks;
    logic [31:0]   r_running_checksum, n_running_checksum;
    logic [CW-1:0] r_bytes_in_chunk, n_bytes_in_chunk;
    logic [31:0]   r_saved_checksum, n_saved_checksum;

    // Result register.
    logic               r_out_valid;
    asfc_pkg::t_kind    r_kind;
    asfc_pkg::t_err     r_error_code;
    logic [31:0]        r_stream_seq;
    logic [15:0]        r_chunk_index;
    logic [10:0]        r_chunk_size;
    logic [23:0]        r_bytes_received;
    logic [31:0]        r_checksum;
    logic               r_final_chunk;
    logic [23:0]        r_out_total_bytes;
    logic [15:0]        r_out_total_chunks;

    // Result computed for the command at the input.
    logic               res_valid;
    asfc_pkg::t_kind    res_kind;
    asfc_pkg::t_err     res_err;
    logic [31:0]        res_seq;
    logic [15:0]        res_index;
    logic [10:0]        res_size;
    logic [23:0]        res_recv;
    logic [31:0]        res_sum;
    logic               res_final;
    logic [23:0]        res_tb;
    logic [15:0]        res_tc;

    logic               in_fire;
    asfc_pkg::t_cmd     cmd;
    logic [31:0]        sum_next;
    logic [CW-1:0]      bic_inc;
    logic [24:0]        nb;
    logic [16:0]        nc;
    logic               eb_known, ec_known;
    logic               bytes_done, chunks_done;
    logic [23:0]        end_tb;
    logic [15:0]        end_tc;
    logic               go_error;
    asfc_pkg::t_err     err_code;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign cmd        = asfc_pkg::t_cmd'(i_command);

    // Datapath pieces shared by the decode below.
    assign sum_next    = asfc_pkg::fnv_step(r_running_checksum, i_data_byte);
    assign bic_inc     = (r_bytes_in_chunk <= CHUNK_LIMIT) ? r_bytes_in_chunk + CW'(1)
                                                          : r_bytes_in_chunk;
    assign nb          = {1'b0, r_received_bytes} + 25'(bic_inc);
    assign nc          = {1'b0, r_received_chunks} + 17'd1;
    assign eb_known    = r_expected_bytes != 24'd0;
    assign ec_known    = r_expected_chunks != 16'd0;
    assign bytes_done  = eb_known && (nb >= {1'b0, r_expected_bytes});
    assign chunks_done = ec_known && (nc >= {1'b0, r_expected_chunks});
    assign end_tb      = i_has_total_bytes ? i_total_bytes : r_expected_bytes;
    assign end_tc      = i_has_total_chunks ? i_total_chunks : r_expected_chunks;

    always_comb begin
        n_stream_active    = r_stream_active;
        n_active_seq       = r_active_seq;
        n_expected_bytes   = r_expected_bytes;
        n_expected_chunks  = r_expected_chunks;
        n_received_bytes   = r_received_bytes;
        n_received_chunks  = r_received_chunks;
        n_running_checksum = r_running_checksum;
        n_bytes_in_chunk   = r_bytes_in_chunk;
        n_saved_checksum   = r_saved_checksum;

        res_valid = 1'b0;
        res_kind  = asfc_pkg::KIND_STARTED;
        res_err   = asfc_pkg::ERR_NESTED;
        res_seq   = r_active_seq;
        res_index = 16'd0;
        res_size  = 11'd0;
        res_recv  = 24'd0;
        res_sum   = 32'd0;
        res_final = 1'b0;
        res_tb    = 24'd0;
        res_tc    = 16'd0;

        go_error = 1'b0;
        err_code = asfc_pkg::ERR_NESTED;

        case (cmd)
            asfc_pkg::CMD_START: begin
                if (r_stream_active) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_NESTED;
                end else if ({1'b0, i_declared_chunk_size} > 17'(CHUNK_MAX)) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_TOO_LARGE;
                end else begin
                    n_stream_active    = 1'b1;
                    n_active_seq       = i_seq;
                    n_expected_bytes   = i_total_bytes;
                    n_expected_chunks  = i_total_chunks;
                    n_received_bytes   = 24'd0;
                    n_received_chunks  = 16'd0;
                    n_running_checksum = asfc_pkg::FNV_SEED;
                    n_saved_checksum   = asfc_pkg::FNV_SEED;
                    n_bytes_in_chunk   = '0;
                    res_valid = 1'b1;
                    res_kind  = asfc_pkg::KIND_STARTED;
                    res_seq   = i_seq;
                    res_sum   = asfc_pkg::FNV_SEED;
                    res_tb    = i_total_bytes;
                    res_tc    = i_total_chunks;
                end
            end
            asfc_pkg::CMD_PAYLOAD: begin
                if (!r_stream_active) begin
                    // A stray byte is dropped; only a chunk end is reported.
                    go_error = i_last_in_chunk;
                    err_code = asfc_pkg::ERR_NO_STREAM;
                end else if (!i_last_in_chunk) begin
                    n_running_checksum = sum_next;
                    n_bytes_in_chunk   = bic_inc;
                end else if (bic_inc > CHUNK_LIMIT) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_TOO_LARGE;
                end else if (nb[24] || (eb_known && nb[23:0] > r_expected_bytes)) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_BYTES_OVERRUN;
                end else if (nc[16] || (ec_known && nc[15:0] > r_expected_chunks)) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_CHUNKS_OVERRUN;
                end else begin
                    n_running_checksum = sum_next;
                    n_saved_checksum   = sum_next;
                    n_received_bytes   = nb[23:0];
                    n_received_chunks  = nc[15:0];
                    n_bytes_in_chunk   = '0;
                    res_valid = 1'b1;
                    res_kind  = asfc_pkg::KIND_CHUNK;
                    res_index = nc[15:0];
                    res_size  = 11'(bic_inc);
                    res_recv  = nb[23:0];
                    res_sum   = sum_next;
                    // With both totals known the chunk is final only when
                    // both are reached; otherwise either one suffices.
                    res_final = (eb_known && ec_known) ? (bytes_done && chunks_done)
                                                       : (bytes_done || chunks_done);
                    res_tb    = r_expected_bytes;
                    res_tc    = r_expected_chunks;
                end
            end
            asfc_pkg::CMD_END: begin
                if (!r_stream_active) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_END_NO_START;
                end else if (r_active_seq != 32'd0 && i_seq != 32'd0
                             && r_active_seq != i_seq) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_SEQ;
                end else if (i_has_total_bytes && eb_known
                             && i_total_bytes != r_expected_bytes) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_END_BYTES;
                end else if (i_has_total_chunks && ec_known
                             && i_total_chunks != r_expected_chunks) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_END_CHUNKS;
                end else if (eb_known && r_received_bytes != r_expected_bytes) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_PAYLOAD_BYTES;
                end else if (ec_known && r_received_chunks != r_expected_chunks) begin
                    go_error = 1'b1;
                    err_code = asfc_pkg::ERR_PAYLOAD_CHUNKS;
                end else begin
                    // Bytes of an unfinished chunk are dropped here.
                    n_stream_active    = 1'b0;
                    n_active_seq       = 32'd0;
                    n_expected_bytes   = 24'd0;
                    n_expected_chunks  = 16'd0;
                    n_received_bytes   = 24'd0;
                    n_received_chunks  = 16'd0;
                    n_running_checksum = 32'd0;
                    n_bytes_in_chunk   = '0;
                    n_saved_checksum   = 32'd0;
                    res_valid = 1'b1;
                    res_kind  = asfc_pkg::KIND_ENDED;
                    res_recv  = r_received_bytes;
                    res_sum   = r_saved_checksum;
                    res_tb    = end_tb;
                    res_tc    = end_tc;
                end
            end
            default: begin
                // Unused command code: no effect.
            end
        endcase

        // Every error reports the open sequence number and clears the stream.
        if (go_error) begin
            n_stream_active    = 1'b0;
            n_active_seq       = 32'd0;
            n_expected_bytes   = 24'd0;
            n_expected_chunks  = 16'd0;
            n_received_bytes   = 24'd0;
            n_received_chunks  = 16'd0;
            n_running_checksum = 32'd0;
            n_bytes_in_chunk   = '0;
            n_saved_checksum   = 32'd0;
            res_valid = 1'b1;
            res_kind  = asfc_pkg::KIND_ERROR;
            res_err   = err_code;
            res_seq   = r_active_seq;
            res_index = 16'd0;
            res_size  = 11'd0;
            res_recv  = 24'd0;
            res_sum   = 32'd0;
            res_final = 1'b0;
            res_tb    = 24'd0;
            res_tc    = 16'd0;
        end
    end

    // Stream state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_active    <= 1'b0;
            r_active_seq       <= 32'd0;
            r_expected_bytes   <= 24'd0;
            r_expected_chunks  <= 16'd0;
            r_received_bytes   <= 24'd0;
            r_received_chunks  <= 16'd0;
            r_running_checksum <= 32'd0;
            r_bytes_in_chunk   <= '0;
            r_saved_checksum   <= 32'd0;
        end else if (in_fire) begin
            r_stream_active    <= n_stream_active;
            r_active_seq       <= n_active_seq;
            r_expected_bytes   <= n_expected_bytes;
            r_expected_chunks  <= n_expected_chunks;
            r_received_bytes   <= n_received_bytes;
            r_received_chunks  <= n_received_chunks;
            r_running_checksum <= n_running_checksum;
            r_bytes_in_chunk   <= n_bytes_in_chunk;
            r_saved_checksum   <= n_saved_checksum;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (in_fire && res_valid) begin
            r_kind             <= res_kind;
            r_error_code       <= (res_kind == asfc_pkg::KIND_ERROR) ? res_err
                                                                     : asfc_pkg::ERR_NESTED;
            r_stream_seq       <= res_seq;
            r_chunk_index      <= res_index;
            r_chunk_size       <= res_size;
            r_bytes_received   <= res_recv;
            r_checksum         <= res_sum;
            r_final_chunk      <= res_final;
            r_out_total_bytes  <= res_tb;
            r_out_total_chunks <= res_tc;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_error_code       = r_error_code;
    assign o_stream_seq       = r_stream_seq;
    assign o_chunk_index      = r_chunk_index;
    assign o_chunk_size       = r_chunk_size;
    assign o_bytes_received   = r_bytes_received;
    assign o_checksum         = r_checksum;
    assign o_final_chunk      = r_final_chunk;
    assign o_out_total_bytes  = r_out_total_bytes;
    assign o_out_total_chunks = r_out_total_chunks;

    // A closed stream always holds cleared counters and checksum.
    a_closed_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stream_active |-> (r_active_seq == 32'd0 && r_received_bytes == 24'd0
                              && r_received_chunks == 16'd0 && r_running_checksum == 32'd0))
        else $error("closed stream holds stale state");

    // The per-chunk counter never passes its saturation point.
    a_chunk_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_in_chunk <= CW'(CHUNK_MAX + 1))
        else $error("chunk byte counter past saturation");

    // Committed chunks never exceed a known declared total.
    a_chunks_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stream_active && r_expected_chunks != 16'd0)
            |-> r_received_chunks <= r_expected_chunks)
        else $error("committed chunks exceed declared total");

    // A stalled result blocks new commands so it cannot be overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("command accepted over a stalled result");

    // Only error results carry a nonzero error code.
    a_err_code_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != asfc_pkg::KIND_ERROR) |-> r_error_code == asfc_pkg::ERR_NESTED)
        else $error("error code on a non-error result");

endmodule

`default_nettype wire

// ----- tb/sv/tb_audio_stream_frame_checker_unit.sv -----
// Self-checking testbench for audio_stream_frame_checker_unit.
// Holds its own stream tracker, a queued request driver and a result monitor.
// Depends on asfc_pkg and the unit itself; reads no files.
module tb_audio_stream_frame_checker_unit;

    localparam int CHUNK_MAX       = 1024;
    localparam int ITEMS_PER_PHASE = 200;

    // One command request as the sender presents it. The drain flag holds the
    // request back until every outstanding result has been delivered.
    typedef struct {
        asfc_pkg::t_cmd cmd;
        logic [31:0]    seq;
        logic [7:0]     data;
        logic           last;
        logic [23:0]    tb;
        logic [15:0]    tc;
        logic [15:0]    dcs;
        logic           has_tb;
        logic           has_tc;
        bit             drain;
    } t_cmd_req;

    // One result request as the unit should deliver it.
    typedef struct {
        asfc_pkg::t_kind kind;
        asfc_pkg::t_err  err;
        logic [31:0]     seq;
        logic [15:0]     idx;
        logic [10:0]     size;
        logic [23:0]     recv;
        logic [31:0]     sum;
        logic            fin;
        logic [23:0]     tb;
        logic [15:0]     tc;
    } t_frame_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Command channel, driven only from the request driver below.
    logic        in_valid = 1'b0;
    logic [1:0]  req_command = '0;
    logic [31:0] req_seq = '0;
    logic [7:0]  req_data = '0;
    logic        req_last = 1'b0;
    logic [23:0] req_tb = '0;
    logic [15:0] req_tc = '0;
    logic [15:0] req_dcs = '0;
    logic        req_has_tb = 1'b0;
    logic        req_has_tc = 1'b0;
    logic        in_ready;

    // Result channel.
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  res_kind;
    logic [3:0]  res_error_code;
    logic [31:0] res_stream_seq;
    logic [15:0] res_chunk_index;
    logic [10:0] res_chunk_size;
    logic [23:0] res_bytes_received;
    logic [31:0] res_checksum;
    logic        res_final_chunk;
    logic [23:0] res_total_bytes;
    logic [15:0] res_total_chunks;

    // Commands waiting to be sent, results waiting to arrive.
    t_cmd_req      pend_q[$];
    t_frame_result result_q[$];
    t_cmd_req      cur_req;
    int            fed_count = 0;
    bit            hold_next = 1'b0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            mismatch_count = 0;

    // Tracker copy of the stream state, updated in acceptance order.
    bit          st_open = 1'b0;
    logic [31:0] st_seq = '0;
    logic [23:0] st_want_bytes = '0;
    logic [15:0] st_want_chunks = '0;
    logic [23:0] st_got_bytes = '0;
    logic [15:0] st_got_chunks = '0;
    logic [31:0] st_sum = '0;
    logic [10:0] st_fill = '0;
    logic [31:0] st_commit_sum = '0;

    audio_stream_frame_checker_unit #(
        .CHUNK_MAX(CHUNK_MAX)
    ) i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (in_valid),
        .o_in_ready            (in_ready),
        .i_command             (req_command),
        .i_seq                 (req_seq),
        .i_data_byte           (req_data),
        .i_last_in_chunk       (req_last),
        .i_total_bytes         (req_tb),
        .i_total_chunks        (req_tc),
        .i_declared_chunk_size (req_dcs),
        .i_has_total_bytes     (req_has_tb),
        .i_has_total_chunks    (req_has_tc),
        .o_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .o_kind                (res_kind),
        .o_error_code          (res_error_code),
        .o_stream_seq          (res_stream_seq),
        .o_chunk_index         (res_chunk_index),
        .o_chunk_size          (res_chunk_size),
        .o_bytes_received      (res_bytes_received),
        .o_checksum            (res_checksum),
        .o_final_chunk         (res_final_chunk),
        .o_out_total_bytes     (res_total_bytes),
        .o_out_total_chunks    (res_total_chunks)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stream tracker
    // ------------------------------------------------------------------

    // FNV-1a folds one byte: xor it into the low end, then multiply by the
    // prime modulo 2^32.
    function automatic logic [31:0] fnv1a_fold(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'd0, b}) * asfc_pkg::FNV_PRIME;
    endfunction

    function automatic void clear_tracker();
        st_open        = 1'b0;
        st_seq         = '0;
        st_want_bytes  = '0;
        st_want_chunks = '0;
        st_got_bytes   = '0;
        st_got_chunks  = '0;
        st_sum         = '0;
        st_fill        = '0;
        st_commit_sum  = '0;
    endfunction

    // Every error reports the sequence number of the stream it kills, then
    // drops the whole stream.
    function automatic bit stream_error(asfc_pkg::t_err code, inout t_frame_result res);
        res.kind = asfc_pkg::KIND_ERROR;
        res.err  = code;
        res.seq  = st_seq;
        clear_tracker();
        return 1'b1;
    endfunction

    // Applies one accepted command to the tracker. Returns 1 when the command
    // produces a result, which is then returned in res.
    function automatic bit track_command(input t_cmd_req r, output t_frame_result res);
        logic [31:0] nb;
        logic [16:0] nc;
        logic [23:0] eb;
        logic [15:0] ec;
        bit          bd;
        bit          cd;
        // All fields that a result kind does not use read as zero, the error
        // code included.
        res.kind = asfc_pkg::KIND_STARTED;
        res.err  = asfc_pkg::ERR_NESTED;
        res.seq  = '0;
        res.idx  = '0;
        res.size = '0;
        res.recv = '0;
        res.sum  = '0;
        res.fin  = 1'b0;
        res.tb   = '0;
        res.tc   = '0;
        case (r.cmd)
            asfc_pkg::CMD_START: begin
                if (st_open) return stream_error(asfc_pkg::ERR_NESTED, res);
                if (r.dcs > CHUNK_MAX) return stream_error(asfc_pkg::ERR_TOO_LARGE, res);
                clear_tracker();
                st_open        = 1'b1;
                st_seq         = r.seq;
                st_want_bytes  = r.tb;
                st_want_chunks = r.tc;
                st_sum         = asfc_pkg::FNV_SEED;
                st_commit_sum  = asfc_pkg::FNV_SEED;
                res.kind = asfc_pkg::KIND_STARTED;
                res.seq  = st_seq;
                res.sum  = st_sum;
                res.tb   = st_want_bytes;
                res.tc   = st_want_chunks;
                return 1'b1;
            end
            asfc_pkg::CMD_PAYLOAD: begin
                // Stray bytes are dropped silently unless they close a chunk.
                if (!st_open)
                    return r.last ? stream_error(asfc_pkg::ERR_NO_STREAM, res) : 1'b0;
                st_sum = fnv1a_fold(st_sum, r.data);
                // The fill count stops one past the limit.
                if (st_fill <= CHUNK_MAX) st_fill = st_fill + 11'd1;
                if (!r.last) return 1'b0;
                if (st_fill > CHUNK_MAX) return stream_error(asfc_pkg::ERR_TOO_LARGE, res);
                nb = st_got_bytes + st_fill;
                nc = st_got_chunks + 17'd1;
                if (nb > 32'hFF_FFFF || (st_want_bytes != 0 && nb > st_want_bytes))
                    return stream_error(asfc_pkg::ERR_BYTES_OVERRUN, res);
                if (nc > 17'hFFFF || (st_want_chunks != 0 && nc > st_want_chunks))
                    return stream_error(asfc_pkg::ERR_CHUNKS_OVERRUN, res);
                bd = st_want_bytes != 0 && nb >= st_want_bytes;
                cd = st_want_chunks != 0 && nc >= st_want_chunks;
                res.kind = asfc_pkg::KIND_CHUNK;
                res.seq  = st_seq;
                res.idx  = nc[15:0];
                res.size = st_fill;
                res.recv = nb[23:0];
                res.sum  = st_sum;
                res.fin  = (st_want_bytes != 0 && st_want_chunks != 0) ? (bd && cd)
                                                                       : (bd || cd);
                res.tb   = st_want_bytes;
                res.tc   = st_want_chunks;
                st_got_bytes  = nb[23:0];
                st_got_chunks = nc[15:0];
                st_commit_sum = st_sum;
                st_fill       = '0;
                return 1'b1;
            end
            asfc_pkg::CMD_END: begin
                if (!st_open) return stream_error(asfc_pkg::ERR_END_NO_START, res);
                if (st_seq != 0 && r.seq != 0 && st_seq != r.seq)
                    return stream_error(asfc_pkg::ERR_SEQ, res);
                eb = r.has_tb ? r.tb : st_want_bytes;
                ec = r.has_tc ? r.tc : st_want_chunks;
                if (r.has_tb && st_want_bytes != 0 && eb != st_want_bytes)
                    return stream_error(asfc_pkg::ERR_END_BYTES, res);
                if (r.has_tc && st_want_chunks != 0 && ec != st_want_chunks)
                    return stream_error(asfc_pkg::ERR_END_CHUNKS, res);
                if (st_want_bytes != 0 && st_got_bytes != st_want_bytes)
                    return stream_error(asfc_pkg::ERR_PAYLOAD_BYTES, res);
                if (st_want_chunks != 0 && st_got_chunks != st_want_chunks)
                    return stream_error(asfc_pkg::ERR_PAYLOAD_CHUNKS, res);
                // An unfinished chunk is thrown away: the end reports the
                // committed totals and the checksum of the last closed chunk.
                res.kind = asfc_pkg::KIND_ENDED;
                res.seq  = st_seq;
                res.recv = st_got_bytes;
                res.sum  = st_commit_sum;
                res.tb   = eb;
                res.tc   = ec;
                clear_tracker();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    // Fields that a command does not use are filled at random so that every
    // input bit toggles.
    function automatic t_cmd_req blank_req(asfc_pkg::t_cmd c);
        t_cmd_req r;
        r.cmd    = c;
        r.seq    = $urandom;
        r.data   = 8'($urandom);
        r.last   = 1'($urandom_range(1));
        r.tb     = 24'($urandom);
        r.tc     = 16'($urandom);
        r.dcs    = 16'($urandom);
        r.has_tb = 1'($urandom_range(1));
        r.has_tc = 1'($urandom_range(1));
        r.drain  = 1'b0;
        return r;
    endfunction

    // Only requests that the unit acts on count toward the item budget.
    task automatic enqueue(t_cmd_req r, bit counted);
        r.drain   = hold_next;
        hold_next = 1'b0;
        pend_q.push_back(r);
        if (counted) fed_count++;
    endtask

    task automatic push_start(logic [31:0] s, logic [23:0] tb, logic [15:0] tc,
                              logic [15:0] dcs);
        t_cmd_req r;
        r     = blank_req(asfc_pkg::CMD_START);
        r.seq = s;
        r.tb  = tb;
        r.tc  = tc;
        r.dcs = dcs;
        enqueue(r, 1'b1);
    endtask

    task automatic push_byte(logic [7:0] b, logic last);
        t_cmd_req r;
        r      = blank_req(asfc_pkg::CMD_PAYLOAD);
        r.data = b;
        r.last = last;
        enqueue(r, 1'b1);
    endtask

    task automatic push_end(logic [31:0] s, logic htb, logic [23:0] tb, logic htc,
                            logic [15:0] tc);
        t_cmd_req r;
        r        = blank_req(asfc_pkg::CMD_END);
        r.seq    = s;
        r.has_tb = htb;
        r.tb     = tb;
        r.has_tc = htc;
        r.tc     = tc;
        enqueue(r, 1'b1);
    endtask

    // A complete stream: start, a few chunks of random bytes, end. With twist
    // set, one thing goes wrong: a declared total too small or too large, an
    // end inside a chunk, a wrong sequence number or wrong end totals.
    task automatic feed_stream(bit twist);
        int          nch;
        int          total;
        int          dev;
        int          roll;
        int          sz[$];
        logic [31:0] s;
        logic [31:0] es;
        logic [23:0] tb;
        logic [23:0] end_tb;
        logic [15:0] tc;
        logic [15:0] end_tc;
        bit          kb;
        bit          kc;
        bit          htb;
        bit          htc;
        nch   = $urandom_range(1, 5);
        total = 0;
        // Mostly short chunks; now and then one near or past the size limit.
        repeat (nch) begin
            roll = $urandom_range(999);
            if (roll < 900) sz.push_back($urandom_range(1, 8));
            else if (roll < 997) sz.push_back($urandom_range(9, 64));
            else sz.push_back($urandom_range(CHUNK_MAX - 24, CHUNK_MAX + 6));
            total += sz[$];
        end
        kb  = 1'($urandom_range(1));
        kc  = 1'($urandom_range(1));
        tb  = kb ? 24'(total) : 24'd0;
        tc  = kc ? 16'(nch) : 16'd0;
        dev = twist ? $urandom_range(1, 8) : 0;
        case (dev)
            1: tb = (total > 1) ? 24'($urandom_range(1, total - 1)) : 24'd1;
            2: tc = (nch > 1) ? 16'(nch - 1) : 16'd1;
            3: tb = 24'(total + $urandom_range(1, 64));
            4: tc = 16'(nch + $urandom_range(1, 3));
            default: ;
        endcase
        s = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
        push_start(s, tb, tc, 16'($urandom_range(0, CHUNK_MAX)));
        foreach (sz[i]) begin
            for (int j = 0; j < sz[i]; j++) push_byte(8'($urandom), j == sz[i] - 1);
        end
        if (dev == 5) begin
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom), 1'b0);
        end
        roll = $urandom_range(9);
        es = (roll < 5) ? s : (roll < 9) ? 32'd0 : $urandom;
        if (dev == 6) es = ~s;
        htb    = 1'($urandom_range(1));
        end_tb = kb ? tb : 24'($urandom);
        htc    = 1'($urandom_range(1));
        end_tc = kc ? tc : 16'($urandom);
        if (dev == 7) begin
            htb    = 1'b1;
            end_tb = tb + 24'd1;
        end
        if (dev == 8) begin
            htc    = 1'b1;
            end_tc = tc + 16'd1;
        end
        push_end(es, htb, end_tb, htc, end_tc);
    endtask

    // Short broken or meaningless sequences; each leaves no stream open.
    task automatic feed_noise();
        t_cmd_req r;
        case ($urandom_range(5))
            0: begin
                repeat ($urandom_range(1, 3)) begin
                    r = blank_req(asfc_pkg::CMD_PAYLOAD);
                    enqueue(r, r.last);
                end
            end
            1: push_end($urandom, 1'($urandom_range(1)), 24'($urandom),
                        1'($urandom_range(1)), 16'($urandom));
            2: enqueue(blank_req(asfc_pkg::CMD_UNUSED), 1'b0);
            3: push_start($urandom, 24'($urandom), 16'($urandom),
                          16'($urandom_range(CHUNK_MAX + 1, 65535)));
            4: begin
                push_start($urandom, 24'($urandom), 16'($urandom),
                           16'($urandom_range(0, CHUNK_MAX)));
                push_start($urandom, 24'($urandom), 16'($urandom), 16'($urandom));
            end
            default: begin
                push_start($urandom, $urandom_range(1) ? 24'($urandom) : 24'd0,
                           $urandom_range(1) ? 16'($urandom) : 16'd0,
                           16'($urandom_range(0, CHUNK_MAX)));
                push_end($urandom_range(1) ? 32'($urandom) : 32'd0,
                         1'($urandom_range(1)), 24'($urandom),
                         1'($urandom_range(1)), 16'($urandom));
            end
        endcase
    endtask

    task automatic feed_random(int quota);
        int stop_at;
        stop_at = fed_count + quota;
        while (fed_count < stop_at) begin
            // Now and then the sender waits for the result side to drain.
            if ($urandom_range(99) < 2) hold_next = 1'b1;
            if ($urandom_range(99) < 70) feed_stream($urandom_range(3) == 0);
            else feed_noise();
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // At each rising edge the driver first books an accepted request into the
    // tracker, which queues the result it should cause. The slot is then free
    // for the next request, unless the sender idles this cycle or the next
    // request must wait for all outstanding results. A request that has not
    // been accepted stays on the port unchanged, so in_valid is assigned at
    // most once per edge.
    always @(posedge i_clk) begin
        t_cmd_req      nxt;
        t_frame_result res;
        bit            slot_free;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            clear_tracker();
            result_q.delete();
        end else begin
            slot_free = !in_valid || in_ready;
            if (in_valid && in_ready) begin
                if (track_command(cur_req, res)) result_q.push_back(res);
            end
            if (slot_free) begin
                if (pend_q.size() != 0 && !(pend_q[0].drain && result_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    nxt         = pend_q.pop_front();
                    cur_req     = nxt;
                    req_command <= nxt.cmd;
                    req_seq     <= nxt.seq;
                    req_data    <= nxt.data;
                    req_last    <= nxt.last;
                    req_tb      <= nxt.tb;
                    req_tc      <= nxt.tc;
                    req_dcs     <= nxt.dcs;
                    req_has_tb  <= nxt.has_tb;
                    req_has_tc  <= nxt.has_tc;
                    in_valid    <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Each delivered result is matched against the oldest expectation. The
    // receiver stalls at random, one decision per cycle.
    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    $error("result with no request waiting: kind %0d", res_kind);
                    mismatch_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("kind", want.kind, res_kind);
                    check_field("error_code", want.err, res_error_code);
                    check_field("stream_seq", want.seq, res_stream_seq);
                    check_field("chunk_index", want.idx, res_chunk_index);
                    check_field("chunk_size", want.size, res_chunk_size);
                    check_field("bytes_received", want.recv, res_bytes_received);
                    check_field("checksum", want.sum, res_checksum);
                    check_field("final_chunk", want.fin, res_final_chunk);
                    check_field("out_total_bytes", want.tb, res_total_bytes);
                    check_field("out_total_chunks", want.tc, res_total_chunks);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and run control
    // ------------------------------------------------------------------

    initial begin
        logic [7:0]  zero_tail [logic [23:0]];
        logic [7:0]  zp [5];
        logic [31:0] p_inv;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] h3;
        logic [31:0] t;
        bit          found;
        t_cmd_req    r;

        // Search a five-byte payload that drives the checksum to zero. The
        // last two bytes are solved backward through the inverse of the prime,
        // so only the first three need a search, which ends quickly.
        p_inv = asfc_pkg::FNV_PRIME;
        repeat (5) p_inv = p_inv * (32'd2 - asfc_pkg::FNV_PRIME * p_inv);
        for (int b = 0; b < 256; b++) begin
            t = 32'(b) * p_inv;
            zero_tail[t[31:8]] = 8'(b);
        end
        found = 1'b0;
        for (int a = 0; a < 256 && !found; a++) begin
            h1 = fnv1a_fold(asfc_pkg::FNV_SEED, 8'(a));
            for (int b = 0; b < 256 && !found; b++) begin
                h2 = fnv1a_fold(h1, 8'(b));
                for (int c = 0; c < 256 && !found; c++) begin
                    h3 = fnv1a_fold(h2, 8'(c));
                    if (zero_tail.exists(h3[31:8])) begin
                        zp[0] = 8'(a);
                        zp[1] = 8'(b);
                        zp[2] = 8'(c);
                        zp[4] = zero_tail[h3[31:8]];
                        t     = 32'(zp[4]) * p_inv;
                        zp[3] = h3[7:0] ^ t[7:0];
                        found = 1'b1;
                    end
                end
            end
        end

        // Directed part. A reserved command and a stray byte are ignored; a
        // stray byte that closes a chunk and an end with no stream are errors.
        enqueue(blank_req(asfc_pkg::CMD_UNUSED), 1'b0);
        r = blank_req(asfc_pkg::CMD_PAYLOAD);
        r.last = 1'b0;
        enqueue(r, 1'b0);
        r.last = 1'b1;
        enqueue(r, 1'b1);
        push_end($urandom, 1'b1, 24'($urandom), 1'b1, 16'($urandom));
        // Declared chunk size one past the limit opens nothing; at the limit,
        // with every other field at its maximum, the stream opens.
        push_start('1, '1, '1, 16'(CHUNK_MAX + 1));
        push_start('1, '1, '1, 16'(CHUNK_MAX));
        // A start inside an open stream kills it and opens nothing.
        push_start('0, '0, '0, '0);
        // The checksum passes through zero and carries on without a reseed.
        push_start(32'h0000_0001, '0, '0, '0);
        if (found) begin
            for (int i = 0; i < 5; i++) push_byte(zp[i], i == 4);
        end
        push_byte(8'hFF, 1'b1);
        // The end arrives inside an open chunk whose byte is discarded; the
        // reported totals sit at their maximum.
        push_byte(8'h00, 1'b0);
        push_end('0, 1'b1, '1, 1'b1, '1);
        // Declared totals reached, then exceeded by one more chunk.
        push_start(32'hA5A5_0001, 24'd1, 16'd0, 16'd1);
        push_byte(8'($urandom), 1'b1);
        push_byte(8'($urandom), 1'b1);
        push_start(32'h5A5A_0002, 24'd0, 16'd1, 16'(CHUNK_MAX));
        push_byte(8'($urandom), 1'b1);
        push_byte(8'($urandom), 1'b1);
        // Sequence number at the end differs from the one at the start.
        push_start(32'h0000_0003, '0, '0, '0);
        push_end(32'h0000_0004, 1'b0, '0, 1'b0, '0);

        // One long chunk, only without idling: it runs past the size limit
        // so that the per-chunk counter saturates before the chunk closes.
        push_start($urandom, '0, '0, 16'(CHUNK_MAX));
        for (int i = 0; i < CHUNK_MAX + 6; i++) push_byte(8'($urandom), i == CHUNK_MAX + 5);

        feed_random(ITEMS_PER_PHASE);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // Sender mostly idle. The first request waits for an empty result side.
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        hold_next      = 1'b1;
        feed_random(ITEMS_PER_PHASE);
        wait_drained();

        // Receiver mostly stalling.
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        feed_random(ITEMS_PER_PHASE);
        wait_drained();

        // Both sides idle now and then.
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        feed_random(ITEMS_PER_PHASE);
        wait_drained();

        // The unit answers in the cycle after a command; the wait below catches any stray result.
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- audio_stream_frame_checker_unit.f -----
design/asfc_pkg.sv
design/audio_stream_frame_checker_unit.sv
tb/sv/tb_audio_stream_frame_checker_unit.sv
